[src/prefix_sum_budget_search_unit_assert.svh]
// Assertion macros used by the prefix sum budget search unit.
`ifndef PREFIX_SUM_BUDGET_SEARCH_UNIT_ASSERT_SVH
`define PREFIX_SUM_BUDGET_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PSBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PSBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PSBS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define PSBS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[src/psbs_pkg.sv]
// Shared constants and types of the prefix sum budget search unit.
package psbs_pkg;

    localparam int OP_W     = 2;
    localparam int AMOUNT_W = 32;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } state_t;

endpackage

[src/psbs_if.sv]
// Handshake channels for the prefix sum budget search unit.
interface psbs_in_if
    import psbs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [AMOUNT_W-1:0] amount;

    modport source (output valid, output op, output amount, input ready);
    modport sink   (input valid, input op, input amount, output ready);
endinterface

interface psbs_out_if
    import psbs_pkg::*;
#(
    parameter int CNT_W = 11
);
    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    item_count;
    logic [AMOUNT_W-1:0] leftover;

    modport source (output valid, output item_count, output leftover, input ready);
    modport sink   (input valid, input item_count, input leftover, output ready);
endinterface

[src/prefix_sum_budget_search_unit.sv]
// Prefix sum budget search unit: a table of running cost totals searched by budget.
//
// Clear and append items are handled in the idle state: an append adds its cost to the
// last running total held in a register and writes the sum into the next free
// entry of a DEPTH-entry memory, so no read is needed. A query is accepted
// and issues its first probe; then each of the CNT_W = clog2(DEPTH + 1) bits
// of the answer (11 at DEPTH 1024) is searched, and after the last bit the
// result is formed. The search decides one bit of the answer per
// cycle, from the most significant down, by reading one running total from the
// single memory read port and comparing it with the budget; the address of the
// next probe is chosen in the same cycle as the compare. The running total of
// the last accepted probe is kept, so the leftover budget needs no second read.
// The input channel is not ready while a query is in progress. A finished
// result waits in an output register; if that register is still occupied, the
// query holds in its final state until the result is taken. Appends beyond
// DEPTH entries are dropped, op code 3 is ignored, and there is no clearing
// pass after reset: the entry count alone bounds every read.
`include "prefix_sum_budget_search_unit_assert.svh"

module prefix_sum_budget_search_unit
    import psbs_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    psbs_in_if.sink     in_ch,
    psbs_out_if.source  out_ch
);

    // Index into the table, entry count (which may equal DEPTH), running sums.
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = AMOUNT_W + IDX_W;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] TOP_STEP  = CNT_W'(1) << (CNT_W - 1);
    localparam logic [CNT_W-1:0] TOP_DEC   = TOP_STEP - CNT_W'(1);

    // Running totals, written on append and read during a search.
    logic [SUM_W-1:0] totals_mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] wr_data;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SUM_W-1:0]    last_total_reg, last_total_next;
    logic [AMOUNT_W-1:0] budget_reg, budget_next;
    logic [SUM_W-1:0]    spent_reg, spent_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                ok_reg, ok_next;

    logic                out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]    out_count_reg, out_count_next;
    logic [AMOUNT_W-1:0] out_left_reg, out_left_next;

    logic             in_fire;
    logic             slot_free;
    logic             take;
    logic [CNT_W-1:0] step_half;
    logic [CNT_W-1:0] probe_next;
    logic [CNT_W-1:0] probe_dec;
    logic [SUM_W-1:0] budget_ext;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.item_count = out_count_reg;
    assign out_ch.leftover   = out_left_reg;

    // The probe just read is taken when it lies inside the table and its
    // running total fits the budget. Totals never decrease, so the answer
    // can be built one bit at a time.
    assign budget_ext = {{(SUM_W - AMOUNT_W){1'b0}}, budget_reg};
    assign take       = ok_reg && (rd_data_reg <= budget_ext);
    assign step_half  = step_reg >> 1;
    assign probe_next = take ? (pos_reg | step_reg | step_half) : (pos_reg | step_half);
    assign probe_dec  = probe_next - CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_total_next = last_total_reg;
        budget_next     = budget_reg;
        spent_next      = spent_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        ok_next         = ok_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_count_next  = out_count_reg;
        out_left_next   = out_left_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data         = last_total_reg + {{(SUM_W - AMOUNT_W){1'b0}}, in_ch.amount};

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_ch.op)
                        OP_CLEAR:
                        begin
                            count_next      = '0;
                            last_total_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (count_reg < DEPTH_CNT)
                            begin
                                wr_en           = 1'b1;
                                last_total_next = wr_data;
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            budget_next = in_ch.amount;
                            spent_next  = '0;
                            pos_next    = '0;
                            step_next   = TOP_STEP;
                            ok_next     = (TOP_STEP <= count_reg);
                            rd_en       = (TOP_STEP <= count_reg);
                            rd_addr     = TOP_DEC[IDX_W-1:0];
                            state_next  = S_SEARCH;
                        end
                        default:
                        begin
                            // Unused op code: no effect.
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (take)
                begin
                    pos_next   = pos_reg | step_reg;
                    spent_next = rd_data_reg;
                end
                if (step_reg[0])
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_half;
                    ok_next   = (probe_next <= count_reg);
                    rd_en     = (probe_next <= count_reg);
                    rd_addr   = probe_dec[IDX_W-1:0];
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = pos_reg;
                    out_left_next  = budget_reg - spent_reg[AMOUNT_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            totals_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= totals_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            last_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_total_reg <= last_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg    <= budget_next;
        spent_reg     <= spent_next;
        pos_reg       <= pos_next;
        step_reg      <= step_next;
        ok_reg        <= ok_next;
        out_count_reg <= out_count_next;
        out_left_reg  <= out_left_next;
    end

    // The table never holds more than DEPTH entries.
    `PSBS_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT,
        "entry count exceeds table depth")

    // During a search exactly one answer bit is under test.
    `PSBS_ASSERT_IMP(a_step_onehot, clk, rst_n, state_reg == S_SEARCH, $onehot(step_reg),
        "search step is not a single bit")

    // The cost paid never exceeds the budget, so the leftover cannot wrap.
    `PSBS_ASSERT_IMP(a_spent_fits, clk, rst_n, state_reg == S_DONE, spent_reg <= budget_ext,
        "spent total above budget")

    // The last search bit always leads to the result stage.
    `PSBS_ASSERT_NXT(a_search_ends, clk, rst_n, (state_reg == S_SEARCH) && step_reg[0],
        state_reg == S_DONE, "search did not finish after its last bit")

endmodule

[bench/tb_top.sv]
// Self-checking bench for the prefix sum budget search unit: scoreboarded cost loads and queries.
module tb_top
    import psbs_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;

    // Op code 3 has no function in the block; it must be dropped without effect.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Roughly how many meaningful input items the run is meant to send.
    localparam int ITEM_TARGET = 1450;

    // Cycles without any handshake before the run is declared hung. The limit
    // stays well above a whole query plus the longest input gap and output stall.
    localparam int HANG_LIMIT = 2000;

    // Cycles allowed after the last answer for anything stray to show up.
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [AMOUNT_W-1:0] amount;
    } request_t;

    typedef struct packed {
        logic [10:0]         item_count;
        logic [AMOUNT_W-1:0] leftover;
    } budget_answer_t;

    logic clk;
    logic rst_n;

    psbs_in_if                   in_ch ();
    psbs_out_if #(.CNT_W(11))    out_ch ();

    prefix_sum_budget_search_unit #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Items waiting to be driven, and the answers that queries already
    // accepted by the block are expected to produce, oldest first.
    request_t       requests_pending[$];
    budget_answer_t answers_due[$];

    // Predicted contents of the block: running cost totals, 42 bits wide so
    // that a full table of maximum costs never wraps.
    logic [41:0]    cost_totals[DEPTH];
    int             stored_count;

    // Shadow of the table as the stimulus will leave it, so that query
    // budgets can be aimed at the interesting boundaries.
    logic [63:0]    plan_totals[DEPTH];
    int             plan_count;
    int             planned_items;

    int             mismatch_count;
    int             quiet_cycles;
    logic           in_taken;
    request_t       next_request;

    int             send_gap;
    int             hold_gap;
    bit             send_calm;
    bit             recv_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap lengths: mostly none or a short one, now and then a long one.
    // While a side is in a calm stretch it never idles at all.
    function automatic int idle_gap(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Costs for the short random sequences. Full-range costs push the running
    // totals past 32 bits, small ones keep many entries within reach of a budget.
    function automatic logic [AMOUNT_W-1:0] pick_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(0, 1000);
        if (r < 60)
            return $urandom_range(0, 100000);
        if (r < 75)
            return '0;
        return $urandom;
    endfunction

    // Budgets: either arbitrary, or sitting exactly on, just under or just
    // over one of the running totals, which is where an off-by-one hides.
    function automatic logic [AMOUNT_W-1:0] pick_budget();
        int          mode;
        int          idx;
        logic [63:0] t;
        mode = $urandom_range(0, 7);
        if (mode == 0 || plan_count == 0)
            return $urandom;
        if (mode == 1)
            return $urandom_range(0, 1) ? '0 : '1;
        idx = $urandom_range(0, plan_count - 1);
        t = plan_totals[idx];
        if (t > 64'hFFFF_FFFF)
            return $urandom;
        case (mode)
            2, 3:
                return t[AMOUNT_W-1:0];
            4:
                return (t == 0) ? '0 : t[AMOUNT_W-1:0] - 1'b1;
            5, 6:
            begin
                t = t + $urandom_range(0, 15);
                if (t > 64'hFFFF_FFFF)
                    t = 64'hFFFF_FFFF;
                return t[AMOUNT_W-1:0];
            end
            default:
                return $urandom;
        endcase
    endfunction

    // Queues one item for the driver and tracks what it will do to the table.
    task automatic schedule_item(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
        request_t req;
        req.op = op;
        req.amount = amount;
        requests_pending.push_back(req);
        if (op == OP_CLEAR)
            plan_count = 0;
        else if (op == OP_APPEND && plan_count < DEPTH)
        begin
            plan_totals[plan_count] = (plan_count != 0 ? plan_totals[plan_count - 1] : 64'd0)
                                      + amount;
            plan_count++;
        end
        if (op != OP_UNUSED)
            planned_items++;
    endtask

    // Applies one accepted item to the predicted table. A query finds, by an
    // upper-bound binary search, how many leading totals fit within the budget
    // and queues the answer that the block owes for it.
    task automatic predict_item(input logic [OP_W-1:0] op, input logic [AMOUNT_W-1:0] amount);
        int             lo;
        int             hi;
        int             mid;
        logic [41:0]    spent;
        budget_answer_t ans;
        case (op)
            OP_CLEAR:
                stored_count = 0;
            OP_APPEND:
            begin
                // A full table drops further costs without a word.
                if (stored_count < DEPTH)
                begin
                    cost_totals[stored_count] =
                        (stored_count != 0 ? cost_totals[stored_count - 1] : 42'd0) + amount;
                    stored_count++;
                end
            end
            OP_QUERY:
            begin
                lo = 0;
                hi = stored_count;
                while (lo < hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (cost_totals[mid] > {10'd0, amount})
                        hi = mid;
                    else
                        lo = mid + 1;
                end
                spent = (lo != 0) ? cost_totals[lo - 1] : 42'd0;
                ans.item_count = lo[10:0];
                ans.leftover = amount - spent[AMOUNT_W-1:0];
                answers_due.push_back(ans);
            end
            default:
                ;
        endcase
    endtask

    // Compares one answer from the block with the oldest one still owed.
    task automatic check_answer(input logic [10:0] item_count,
                                input logic [AMOUNT_W-1:0] leftover);
        budget_answer_t want;
        if (answers_due.size() == 0)
        begin
            $error("answer with no query outstanding: item_count %0d, leftover %0d",
                   item_count, leftover);
            mismatch_count++;
        end
        else
        begin
            want = answers_due.pop_front();
            if (item_count !== want.item_count)
            begin
                $error("item_count: expected %0d, actual %0d", want.item_count, item_count);
                mismatch_count++;
            end
            if (leftover !== want.leftover)
            begin
                $error("leftover: expected %0d, actual %0d", want.leftover, leftover);
                mismatch_count++;
            end
        end
    endtask

    // Input driver. It changes the channel at the falling edge only, keeps an
    // item steady until the block has taken it, and then either idles for a
    // while or presents the next item at once. An item that follows directly
    // is put up in the same step without lowering valid first.
    always @(negedge clk)
    begin
        if (rst_n && (!in_ch.valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (requests_pending.size() > 0)
            begin
                next_request = requests_pending.pop_front();
                in_ch.op <= next_request.op;
                in_ch.amount <= next_request.amount;
                in_ch.valid <= 1'b1;
                send_gap <= idle_gap(send_calm);
                if ($urandom_range(0, 63) == 0)
                    send_calm <= !send_calm;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Output side. Ready is raised and then held low for a gap of random length,
    // possibly none, so that a finished answer is at times parked in its output
    // register and a finished query at times has to wait for it to be taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_gap > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_gap <= hold_gap - 1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                hold_gap <= idle_gap(recv_calm);
                if ($urandom_range(0, 63) == 0)
                    recv_calm <= !recv_calm;
            end
        end
    end

    // Monitor, sampling at the rising edge. Answers are checked before the
    // new input is predicted; a query cannot be answered in the cycle it is
    // taken, so the order does not matter. The watchdog lives here as well.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
                check_answer(out_ch.item_count, out_ch.leftover);
            if (in_ch.valid && in_ch.ready)
                predict_item(in_ch.op, in_ch.amount);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_CLEAR;
        in_ch.amount = '0;
        out_ch.ready = 1'b0;
        stored_count = 0;
        plan_count = 0;
        planned_items = 0;
        mismatch_count = 0;
        send_gap = 0;
        hold_gap = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;

        // Directed opening. Queries on an empty table must return the whole
        // budget, at both ends of the budget range.
        schedule_item(OP_QUERY, 32'd0);
        schedule_item(OP_QUERY, 32'hFFFF_FFFF);
        // The unused op code must neither answer nor touch the table.
        schedule_item(OP_UNUSED, 32'hFFFF_FFFF);
        schedule_item(OP_APPEND, 32'd5);
        // First cost above the budget: nothing affordable, budget returned.
        schedule_item(OP_QUERY, 32'd4);
        schedule_item(OP_QUERY, 32'd5);
        // A zero cost makes two equal totals; the search must take both.
        schedule_item(OP_APPEND, 32'd0);
        schedule_item(OP_QUERY, 32'd5);
        // Maximum costs push the totals past 32 bits.
        schedule_item(OP_APPEND, 32'hFFFF_FFFF);
        schedule_item(OP_QUERY, 32'hFFFF_FFFF);
        schedule_item(OP_APPEND, 32'hFFFF_FFFF);
        schedule_item(OP_QUERY, 32'd0);
        schedule_item(OP_UNUSED, 32'h1234_5678);
        schedule_item(OP_QUERY, 32'd6);
        // After a clear the table must read as empty again.
        schedule_item(OP_CLEAR, 32'hFFFF_FFFF);
        schedule_item(OP_QUERY, 32'd7);
        schedule_item(OP_APPEND, 32'd0);
        // Every entry affordable: the count equals the number of entries.
        schedule_item(OP_QUERY, 32'd0);
        schedule_item(OP_APPEND, 32'd1);
        schedule_item(OP_QUERY, 32'd0);
        schedule_item(OP_QUERY, 32'd1);
        schedule_item(OP_QUERY, 32'hFFFF_FFFF);

        // Fill the table to the brim with small costs, so that the grand total
        // still fits a 32-bit budget, and go a few appends past the end to
        // check that they are dropped. Queries along the way see a growing table.
        schedule_item(OP_CLEAR, $urandom);
        for (int i = 0; i < DEPTH + 6; i++)
        begin
            schedule_item(OP_APPEND,
                          ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(0, 4000000));
            if (i % 40 == 39)
                schedule_item(OP_QUERY, pick_budget());
        end
        schedule_item(OP_QUERY, 32'hFFFF_FFFF);
        repeat (8)
            schedule_item(OP_QUERY, pick_budget());

        // Random part: mostly a fresh table with a handful of costs followed by
        // a few aimed queries, with loose single items of any kind in between.
        while (planned_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 9) < 7)
                    schedule_item(OP_CLEAR, $urandom);
                n = $urandom_range(1, 24);
                repeat (n)
                    schedule_item(OP_APPEND, pick_cost());
                n = $urandom_range(1, 6);
                repeat (n)
                    schedule_item(OP_QUERY, pick_budget());
            end
            else
            begin
                schedule_item(2'($urandom_range(0, 3)), $urandom);
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and every answer has arrived,
        // then give a stray extra answer some time to show itself.
        while (requests_pending.size() != 0 || in_ch.valid || answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
